// File: hdl/nbc_pkg.sv
// Shared types, constants and helpers for the naive Bayes classifier.
`default_nettype none
package nbc_pkg;
	localparam int MAX_CLASSES  = 8;
	localparam int MAX_FEATURES = 8;
	localparam int MAX_BINS     = 16;
	localparam int CLS_W  = $clog2(MAX_CLASSES);
	localparam int FEAT_W = $clog2(MAX_FEATURES);
	localparam int BIN_W  = $clog2(MAX_BINS);
	localparam int ADDR_W = CLS_W + FEAT_W + BIN_W;
	localparam int DEPTH  = MAX_CLASSES * MAX_FEATURES * MAX_BINS;

	// divider widths
	localparam int DVD_W = 64;
	localparam int DVS_W = 35;
	localparam int CNT_W = $clog2(DVD_W + 1);

	localparam logic [31:0] Q_ONE      = 32'h8000_0000;
	localparam logic [15:0] LFSR_SEED  = 16'hACE1;
	localparam logic [31:0] THRESH_RST = 32'd6442451;

	// register indexes
	localparam logic [1:0] REG_CLASSES = 2'd0;
	localparam logic [1:0] REG_FEATS   = 2'd1;
	localparam logic [1:0] REG_BINS    = 2'd2;
	localparam logic [1:0] REG_THRESH  = 2'd3;

	// request codes
	localparam logic [1:0] REQ_TRAIN    = 2'd0;
	localparam logic [1:0] REQ_CLASSIFY = 2'd1;
	localparam logic [1:0] REQ_POST     = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] feature_bin;
		logic [2:0] class_label;
		logic       last_feature;
	} nbc_in_t;

	typedef struct packed {
		logic [2:0]  best_class;
		logic [31:0] posterior;
		logic        result_kind;
	} nbc_out_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE,
		ST_TM0, ST_TM1, ST_TRD, ST_TMUL, ST_TDIV, ST_TWAIT,
		ST_PMUL, ST_PDIV, ST_PWAIT,
		ST_MODS, ST_MODW,
		ST_SINIT, ST_SRD, ST_SMUL, ST_SACC, ST_CEND,
		ST_QDIV, ST_QWAIT, ST_OUT
	} nbc_state_t;

	// saturate a quotient at 1.0
	function automatic logic [31:0] sat_one(input logic [DVD_W-1:0] v);
		logic [31:0] r;
		if (v > {{(DVD_W-32){1'b0}}, Q_ONE}) r = Q_ONE;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hdl/nbc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nbc_div import nbc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [DVS_W-1:0] div_q, rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q, done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	// one shift-subtract step
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (run_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, div_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

// File: hdl/naive_bayes_classifier.sv
// Top level: sequencer, probability table, shared multiplier and divider.
//
// Usage: items enter on req, accepted when start is high and busy is low.
// Each item carries one feature bin; the item with last_feature set closes
// the sample and its req_type says what to do. Items that do not close a
// sample leave busy low.
// Train: states TM0 and TM1 form the label's sample count, then each (feature, bin)
// entry of the label is read, multiplied, divided and written back, then the
// priors of every class are updated; no result.
// Classify: a divide picks the fallback class, then each class is scored on
// the shared multiplier, followed by the OUT state; one result.
// Posterior: the same scoring, a divide and the OUT state; one result.
// Busy falls as the result appears; the next sample may start at once.
// A result sits on the result port for one cycle with done high; the
// receiver cannot stall, so nothing is held back.
// Configuration writes on cfg_we take effect at the next edge and are read
// all through an operation, so they belong in cycles where busy is low.
// Reset: a clearing pass writes zero to all 1024 table entries, one a cycle;
// busy stays high until the pass ends.
`default_nettype none
module naive_bayes_classifier import nbc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire nbc_in_t     req,
	output logic             busy,
	output logic             done,
	output nbc_out_t         result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	nbc_state_t state_q, state_d;

	// configuration
	logic [3:0]  classes_q, feats_q;
	logic [4:0]  bins_q;
	logic [31:0] thresh_q;
	logic [3:0]  nc, nf;
	logic [4:0]  nb;

	// model state
	logic [31:0]       prior_q [MAX_CLASSES];
	logic [31:0]       count_q;
	logic [BIN_W-1:0]  sbins_q [MAX_FEATURES];
	logic [FEAT_W-1:0] pos_q;
	logic [15:0]       lfsr_q, lfsr_next;
	logic [ADDR_W-1:0] clr_q;

	// working registers
	logic [1:0]        kind_q;
	logic [CLS_W-1:0]  label_q, c_q, pick_q;
	logic [FEAT_W-1:0] f_q;
	logic [BIN_W-1:0]  b_q;
	logic [32:0]       m_q;
	logic [64:0]       prod_q;
	logic [31:0]       s_q, best_q, mine_q, post_q;
	logic [34:0]       sum_q;
	logic              done_q;
	nbc_out_t          result_q;

	// table
	logic [31:0]       mem [DEPTH];
	logic [31:0]       rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0]       wdata;

	// shared units
	logic [31:0] mul_a;
	logic [32:0] mul_b;
	div_req_t    dreq;
	div_rsp_t    drsp;

	logic accept, last_c, last_f, last_b, bin_ok, hit, label_ok;
	logic [63:0] m_sum;

	nbc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// clamped configuration
	always_comb begin
		nc = (classes_q == 4'd0) ? 4'd1 : (classes_q > 4'(MAX_CLASSES)) ? 4'(MAX_CLASSES)
			: classes_q;
		nf = (feats_q == 4'd0) ? 4'd1 : (feats_q > 4'(MAX_FEATURES)) ? 4'(MAX_FEATURES)
			: feats_q;
		nb = (bins_q == 5'd0) ? 5'd1 : (bins_q > 5'(MAX_BINS)) ? 5'(MAX_BINS) : bins_q;
	end

	always_comb begin
		accept    = start && !busy;
		last_c    = {1'b0, c_q} == nc - 4'd1;
		last_f    = {1'b0, f_q} == nf - 4'd1;
		last_b    = {1'b0, b_q} == nb - 5'd1;
		bin_ok    = {1'b0, sbins_q[f_q]} < nb;
		hit       = b_q == sbins_q[f_q];
		label_ok  = {1'b0, req.class_label} < nc;
		lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
		m_sum     = prod_q[63:0] + 64'h4000_0000;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept && req.last_feature) begin
					case (req.req_type)
						REQ_TRAIN:    if (label_ok) state_d = ST_TM0;
						REQ_CLASSIFY: state_d = ST_MODS;
						REQ_POST:     state_d = ST_SINIT;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_TM0:  state_d = ST_TM1;
			ST_TM1:  state_d = ST_TRD;
			ST_TRD:  state_d = ST_TMUL;
			ST_TMUL: state_d = ST_TDIV;
			ST_TDIV: state_d = ST_TWAIT;
			ST_TWAIT: begin
				if (drsp.done) state_d = (last_b && last_f) ? ST_PMUL : ST_TRD;
			end
			ST_PMUL: state_d = ST_PDIV;
			ST_PDIV: state_d = ST_PWAIT;
			ST_PWAIT: begin
				if (drsp.done) state_d = last_c ? ST_IDLE : ST_PMUL;
			end
			ST_MODS: state_d = ST_MODW;
			ST_MODW: if (drsp.done) state_d = ST_SINIT;
			ST_SINIT: state_d = ST_SRD;
			ST_SRD:   state_d = ST_SMUL;
			ST_SMUL:  state_d = ST_SACC;
			ST_SACC:  state_d = last_f ? ST_CEND : ST_SRD;
			ST_CEND: begin
				if (!last_c) state_d = ST_SINIT;
				else if (kind_q == REQ_CLASSIFY) state_d = ST_OUT;
				else state_d = ST_QDIV;
			end
			ST_QDIV:  state_d = ST_QWAIT;
			ST_QWAIT: if (drsp.done) state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: table ports, multiplier and divider operands
	always_comb begin
		mem_we = 1'b0;
		waddr  = {label_q, f_q, b_q};
		wdata  = sat_one(drsp.quo);
		raddr  = {label_q, f_q, b_q};
		mul_a  = prior_q[c_q];
		mul_b  = {1'b0, count_q};
		dreq   = '{start: 1'b0, dividend: '0, divisor: '0};
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				wdata  = '0;
			end
			ST_TM0: mul_a = prior_q[label_q];
			ST_TMUL: begin
				mul_a = rdata_q;
				mul_b = m_q;
			end
			ST_TDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = prod_q[63:0] + (hit ? 64'h8000_0000 : 64'd0);
				dreq.divisor  = {2'b00, m_q + 33'd1};
			end
			ST_TWAIT: mem_we = drsp.done;
			ST_PDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = prod_q[63:0] + ((c_q == label_q) ? 64'h8000_0000 : 64'd0);
				dreq.divisor  = {2'b00, {1'b0, count_q} + 33'd1};
			end
			ST_MODS: begin
				dreq.start    = 1'b1;
				dreq.dividend = {48'd0, lfsr_q};
				dreq.divisor  = {31'd0, nc};
			end
			ST_SRD: raddr = {c_q, f_q, sbins_q[f_q]};
			ST_SMUL: begin
				mul_a = s_q;
				mul_b = {1'b0, bin_ok ? rdata_q : 32'd0};
			end
			ST_QDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = {1'b0, mine_q, 31'd0};
				dreq.divisor  = sum_q;
			end
			default: ;
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// control and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			classes_q <= 4'd2;
			feats_q   <= 4'd4;
			bins_q    <= 5'd16;
			thresh_q  <= THRESH_RST;
			for (int i = 0; i < MAX_CLASSES; i++) prior_q[i] <= '0;
			count_q   <= '0;
			pos_q     <= '0;
			lfsr_q    <= LFSR_SEED;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_OUT;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					REG_CLASSES: classes_q <= cfg_data[3:0];
					REG_FEATS:   feats_q   <= cfg_data[3:0];
					REG_BINS:    bins_q    <= cfg_data[4:0];
					REG_THRESH:  thresh_q  <= cfg_data;
					default: ;
				endcase
			end
			// feature slot pointer
			if (accept) begin
				if (req.last_feature) pos_q <= '0;
				else if (pos_q != FEAT_W'(MAX_FEATURES - 1)) pos_q <= pos_q + 1'b1;
				if (req.last_feature && req.req_type == REQ_CLASSIFY) lfsr_q <= lfsr_next;
			end
			// prior update and sample count
			if (state_q == ST_PWAIT && drsp.done) begin
				prior_q[c_q] <= sat_one(drsp.quo);
				if (last_c && count_q != 32'hFFFF_FFFF) count_q <= count_q + 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= {33'd0, mul_a} * {32'd0, mul_b};
		if (accept) begin
			sbins_q[pos_q] <= req.feature_bin;
			kind_q  <= req.req_type;
			label_q <= req.class_label;
			c_q     <= '0;
			f_q     <= '0;
			b_q     <= '0;
			sum_q   <= '0;
			mine_q  <= '0;
			post_q  <= '0;
		end
		case (state_q)
			ST_TM1: m_q <= m_sum[63:31];
			ST_TWAIT: begin
				if (drsp.done) begin
					b_q <= last_b ? '0 : b_q + 1'b1;
					if (last_b) f_q <= f_q + 1'b1;
				end
			end
			ST_PWAIT: if (drsp.done) c_q <= c_q + 1'b1;
			ST_MODW: begin
				pick_q <= drsp.rem[CLS_W-1:0];
				best_q <= thresh_q;
			end
			ST_SINIT: begin
				s_q <= prior_q[c_q];
				f_q <= '0;
			end
			ST_SACC: begin
				s_q <= prod_q[62:31];
				f_q <= f_q + 1'b1;
			end
			ST_CEND: begin
				if (s_q > best_q) begin
					best_q <= s_q;
					pick_q <= c_q;
				end
				sum_q <= sum_q + {3'd0, s_q};
				if (c_q == label_q) mine_q <= s_q;
				c_q <= c_q + 1'b1;
			end
			ST_QWAIT: begin
				if (drsp.done && {1'b0, label_q} < nc && sum_q != '0)
					post_q <= sat_one(drsp.quo);
			end
			ST_OUT: begin
				result_q.result_kind <= kind_q == REQ_POST;
				result_q.best_class  <= (kind_q == REQ_POST) ? '0 : pick_q;
				result_q.posterior   <= (kind_q == REQ_POST) ? post_q : '0;
			end
			default: ;
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;
endmodule
`default_nettype wire
